// ===== hw/rtl/two_digit_rainbow_segment_pixels_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rainbow segment pixel block
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TWO_DIGIT_RAINBOW_SEGMENT_PIXELS_MACROS_SVH
`define TWO_DIGIT_RAINBOW_SEGMENT_PIXELS_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TDRSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TDRSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tdrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdrsp_pkg
// Shared types, constants and the digit segment table.
// ----------------------------------------------------------------------------
package tdrsp_pkg;

    localparam int unsigned TEMP_W           = 7;
    localparam int unsigned COLOR_W          = 8;
    localparam int unsigned IDX_W            = 4;
    localparam int unsigned DIGIT_W          = 4;
    localparam int unsigned SEG_W            = 7;
    localparam int unsigned PIXELS_PER_DIGIT = 7;
    localparam int unsigned PIXELS_PER_ITEM  = 2 * PIXELS_PER_DIGIT;

    localparam logic [TEMP_W-1:0]  TEMP_MAX      = 7'd99;
    localparam logic [IDX_W-1:0]   IDX_LAST      = IDX_W'(PIXELS_PER_ITEM - 1);
    localparam logic [IDX_W-1:0]   IDX_DIGIT_END = IDX_W'(PIXELS_PER_DIGIT);
    localparam logic [COLOR_W-1:0] COLOR_FULL    = 8'd255;

    // Segment lamps of one digit, pattern bits 7 down to 1 kept as [6:0]
    typedef logic [SEG_W-1:0] seg_t;

    // One queued display job: ramp colour and both digit patterns
    typedef struct packed {
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] blue;
        seg_t               tens_seg;
        seg_t               units_seg;
    } job_t;

    // Queue head as seen by the pixel sequencer
    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'b1111_1100;
            4'd1:    pat = 8'b0001_1000;
            4'd2:    pat = 8'b1011_0110;
            4'd3:    pat = 8'b0011_1110;
            4'd4:    pat = 8'b0101_1010;
            4'd5:    pat = 8'b0110_1110;
            4'd6:    pat = 8'b1110_1110;
            4'd7:    pat = 8'b0011_1000;
            4'd8:    pat = 8'b1111_1110;
            4'd9:    pat = 8'b0111_1110;
            default: pat = 8'b0000_0000;
        endcase
        return pat;
    endfunction

endpackage

// ===== hw/rtl/tdrsp_front.sv =====
// ----------------------------------------------------------------------------
// tdrsp_front
// Clamps the temperature, splits it into digits and picks the ramp colour.
// ----------------------------------------------------------------------------
module tdrsp_front
(
    input  logic                             in_valid,
    input  logic [tdrsp_pkg::TEMP_W-1:0]     temperature,
    input  logic                             queue_full,
    output logic                             in_stall,
    output logic                             push,
    output tdrsp_pkg::job_t                  job
);

    logic [tdrsp_pkg::TEMP_W-1:0]  temp_clamped;
    logic [14:0]                   tens_prod;
    logic [tdrsp_pkg::DIGIT_W-1:0] tens;
    logic [tdrsp_pkg::TEMP_W-1:0]  tens_x10;
    logic [tdrsp_pkg::DIGIT_W-1:0] units;
    logic [7:0]                    ramp_pos;
    logic [9:0]                    ramp_n;
    logic [9:0]                    ramp_over;
    logic [7:0]                    ramp_m;
    logic [7:0]                    tens_pat;
    logic [7:0]                    units_pat;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        temp_clamped = (temperature > tdrsp_pkg::TEMP_MAX) ? tdrsp_pkg::TEMP_MAX : temperature;
        // divide by ten: multiply by 205/2048, exact over the clamped range 0 to 99
        tens_prod    = 15'(temp_clamped) * 15'd205;
        tens         = tens_prod[14:11];
        tens_x10     = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        units        = 4'(temp_clamped - tens_x10);

        ramp_pos     = {tens, units};
        ramp_n       = 10'({ramp_pos, 2'b00}) + 10'(ramp_pos) + 10'd1;
        ramp_over    = ramp_n - 10'(tdrsp_pkg::COLOR_FULL);
        ramp_m       = (ramp_over > 10'(tdrsp_pkg::COLOR_FULL)) ? tdrsp_pkg::COLOR_FULL
                                                                 : ramp_over[7:0];

        tens_pat     = tdrsp_pkg::seg_pattern(tens);
        units_pat    = tdrsp_pkg::seg_pattern(units);

        if (ramp_n <= 10'(tdrsp_pkg::COLOR_FULL))
        begin
            job.green = ramp_n[7:0];
            job.blue  = tdrsp_pkg::COLOR_FULL - ramp_n[7:0];
            job.red   = '0;
        end
        else
        begin
            job.red   = ramp_m;
            job.green = tdrsp_pkg::COLOR_FULL - ramp_m;
            job.blue  = '0;
        end
        job.tens_seg  = tens_pat[7:1];
        job.units_seg = units_pat[7:1];
    end

endmodule

// ===== hw/rtl/tdrsp_queue.sv =====
// ----------------------------------------------------------------------------
// tdrsp_queue
// Short job queue between the classifier and the pixel sequencer.
// ----------------------------------------------------------------------------
module tdrsp_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tdrsp_pkg::job_t push_job,
    input  logic            pop,
    output logic            full,
    output tdrsp_pkg::head_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tdrsp_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/tdrsp_back.sv =====
// ----------------------------------------------------------------------------
// tdrsp_back
// Walks the fourteen segment pixels of the head job into an output register.
// ----------------------------------------------------------------------------
module tdrsp_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tdrsp_pkg::head_t                  head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tdrsp_pkg::COLOR_W-1:0]     green,
    output logic [tdrsp_pkg::COLOR_W-1:0]     red,
    output logic [tdrsp_pkg::COLOR_W-1:0]     blue,
    output logic [tdrsp_pkg::IDX_W-1:0]       pixel_index,
    output logic                              last_pixel
);

    logic [tdrsp_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                          valid_reg, valid_next;
    logic [tdrsp_pkg::COLOR_W-1:0] green_reg, red_reg, blue_reg;
    logic [tdrsp_pkg::IDX_W-1:0]   pix_reg;
    logic                          last_reg;

    logic                          advance;
    logic                          emit;
    logic                          in_units;
    logic [tdrsp_pkg::IDX_W-1:0]   seg_k;
    tdrsp_pkg::seg_t               seg_sel;
    logic                          lit;
    logic                          at_last;

    assign advance  = !valid_reg || !out_stall;
    assign emit     = advance && head.valid;
    assign at_last  = (idx_reg == tdrsp_pkg::IDX_LAST);
    assign pop      = emit && at_last;

    always_comb
    begin
        in_units = (idx_reg >= tdrsp_pkg::IDX_DIGIT_END);
        seg_k    = in_units ? idx_reg - tdrsp_pkg::IDX_DIGIT_END : idx_reg;
        seg_sel  = in_units ? head.job.units_seg : head.job.tens_seg;
        // scan from the top pattern bit down
        lit      = seg_sel[3'(tdrsp_pkg::SEG_W - 1) - seg_k[2:0]];

        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            green_reg <= lit ? head.job.green : '0;
            red_reg   <= lit ? head.job.red   : '0;
            blue_reg  <= lit ? head.job.blue  : '0;
            pix_reg   <= idx_reg;
            last_reg  <= at_last;
        end
    end

    assign out_valid   = valid_reg;
    assign green       = green_reg;
    assign red         = red_reg;
    assign blue        = blue_reg;
    assign pixel_index = pix_reg;
    assign last_pixel  = last_reg;

endmodule

// ===== hw/rtl/two_digit_rainbow_segment_pixels.sv =====
// With the block idle, an accepted temperature is written into the job queue, and its first
// pixel is then registered onto the outputs, where the receiver takes it while out_stall is low.
// Fourteen pixels go out per temperature, one a cycle while out_stall is low; the pixel
// sequencer walking the queue head sets that rate.
// The job queue lets new temperatures in while pixels of an earlier one still go out.
// Reset (rst_n low, asynchronous) empties the queue, rewinds the pixel counter
// and drops the output valid.
// ----------------------------------------------------------------------------
// two_digit_rainbow_segment_pixels
// Turns a temperature into 14 coloured seven-segment pixels, tens digit first.
// ----------------------------------------------------------------------------
module two_digit_rainbow_segment_pixels
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tdrsp_pkg::TEMP_W-1:0]      temperature,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tdrsp_pkg::COLOR_W-1:0]     green,
    output logic [tdrsp_pkg::COLOR_W-1:0]     red,
    output logic [tdrsp_pkg::COLOR_W-1:0]     blue,
    output logic [tdrsp_pkg::IDX_W-1:0]       pixel_index,
    output logic                              last_pixel
);

    logic             push;
    logic             pop;
    logic             queue_full;
    tdrsp_pkg::job_t  job;
    tdrsp_pkg::head_t head;

    tdrsp_front u_front
    (
        .in_valid    (in_valid),
        .temperature (temperature),
        .queue_full  (queue_full),
        .in_stall    (in_stall),
        .push        (push),
        .job         (job)
    );

    tdrsp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .full     (queue_full),
        .head     (head)
    );

    tdrsp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .green       (green),
        .red         (red),
        .blue        (blue),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel)
    );

endmodule

// ===== hw/rtl/tdrsp_checker.sv =====
// ----------------------------------------------------------------------------
// tdrsp_checker
// Port-level checks on the pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_digit_rainbow_segment_pixels_macros.svh"

module tdrsp_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [tdrsp_pkg::TEMP_W-1:0]      temperature,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [tdrsp_pkg::COLOR_W-1:0]     green,
    input  logic [tdrsp_pkg::COLOR_W-1:0]     red,
    input  logic [tdrsp_pkg::COLOR_W-1:0]     blue,
    input  logic [tdrsp_pkg::IDX_W-1:0]       pixel_index,
    input  logic                              last_pixel
);

    // hold a stalled temperature
    `TDRSP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(temperature), "input moved")

    // hold a stalled pixel
    `TDRSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_index) && $stable(green) && $stable(red) && $stable(blue), "stalled pixel changed")

    `TDRSP_ASSERT_NOW(a_last_flag, out_valid, last_pixel == (pixel_index == tdrsp_pkg::IDX_LAST), "last_pixel disagrees with pixel_index")

    // pixels of a run leave in order
    `TDRSP_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !last_pixel, !out_valid || pixel_index == $past(pixel_index) + 4'd1, "pixel index skipped")

    // the ramp never mixes red and blue
    `TDRSP_ASSERT_NOW(a_ramp_mix, out_valid, red == '0 || blue == '0, "red and blue both lit")

endmodule

bind two_digit_rainbow_segment_pixels tdrsp_checker u_tdrsp_checker (.*);
